### rtl/hsma_pkg.sv
package hsma_pkg;

  // Default sizes of the table.
  localparam int MAX_ENTRIES_DEF  = 256;
  localparam int STATIC_SLOTS_DEF = 1;
  localparam int PAYLOAD_W_DEF    = 32;

  // Fixed widths of the port fields.
  localparam int ACTION_W  = 2;
  localparam int HANDLE_W  = 8;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int LIVE_W    = 9;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_COPY    = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STATIC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEAD   = 2'd3;

endpackage

### rtl/handle_slot_map_allocator.sv
// A request is taken in SIdle; one refused on the counters goes to SDone, and one whose id
// is dead in the map stops at SLook. Read passes SLook, SFetch; create SGetId, SPop (reused
// id), SAlloc; destroy SLook, SMove (not the last entry), SFree; copy SLook, SFetch and the
// create states. SDone hands the result on once an earlier one is no longer stalled. One
// request at a time; the next beat can be taken in the same cycle as the result is offered.
// Reset (asynchronous, active low) sets the counters and sequencer to their start values at
// once; no clearing pass is run, as no map entry above the high-water mark is ever read.
module handle_slot_map_allocator #(
  parameter int MAX_ENTRIES  = hsma_pkg::MAX_ENTRIES_DEF,
  parameter int STATIC_SLOTS = hsma_pkg::STATIC_SLOTS_DEF,
  parameter int PAYLOAD_W    = hsma_pkg::PAYLOAD_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hsma_pkg::ACTION_W-1:0] action_i,
  input  logic [hsma_pkg::HANDLE_W-1:0] handle_id_i,
  input  logic [hsma_pkg::WORD_W-1:0]   payload_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hsma_pkg::STATUS_W-1:0] status_o,
  output logic [hsma_pkg::HANDLE_W-1:0] result_id_o,
  output logic [hsma_pkg::WORD_W-1:0]   payload_out_o,
  output logic [hsma_pkg::LIVE_W-1:0]   live_count_o
);

  localparam int IdW  = $clog2(MAX_ENTRIES);
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CntW > hsma_pkg::HANDLE_W) ? CntW : hsma_pkg::HANDLE_W;
  localparam int MapW = CntW + 1;

  // Sequencer states.
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLook  = 4'd1;
  localparam logic [3:0] SFetch = 4'd2;
  localparam logic [3:0] SGetId = 4'd3;
  localparam logic [3:0] SPop   = 4'd4;
  localparam logic [3:0] SAlloc = 4'd5;
  localparam logic [3:0] SMove  = 4'd6;
  localparam logic [3:0] SFree  = 4'd7;
  localparam logic [3:0] SDone  = 4'd8;

  logic [3:0]                          state_q, state_d;
  logic [hsma_pkg::ACTION_W-1:0]       act_q, act_d;
  logic [hsma_pkg::HANDLE_W-1:0]       hid_q, hid_d;
  logic [hsma_pkg::STATUS_W-1:0]       stat_q, stat_d;
  logic [IdW-1:0]                      newid_q, newid_d;
  logic [IdW-1:0]                      remove_q, remove_d;
  logic [PAYLOAD_W-1:0]                pay_q, pay_d;
  logic [CntW-1:0]                     dense_q, dense_d;
  logic [CntW-1:0]                     hw_q, hw_d;
  logic [CntW-1:0]                     ftop_q, ftop_d;
  logic                                out_valid_q, out_valid_d;
  logic [hsma_pkg::STATUS_W-1:0]       out_status_q, out_status_d;
  logic [hsma_pkg::HANDLE_W-1:0]       out_rid_q, out_rid_d;
  logic [hsma_pkg::WORD_W-1:0]         out_pay_q, out_pay_d;
  logic [hsma_pkg::LIVE_W-1:0]         out_live_q, out_live_d;

  // RAM ports.
  logic                 map_we, pay_we, rev_we, free_we;
  logic [IdW-1:0]       map_waddr, pay_waddr, rev_waddr, free_waddr;
  logic [IdW-1:0]       map_raddr, pay_raddr, rev_raddr, free_raddr;
  logic [MapW-1:0]      map_wdata, map_rdata;
  logic [PAYLOAD_W-1:0] pay_wdata, pay_rdata;
  logic [IdW-1:0]       rev_wdata, rev_rdata, free_wdata, free_rdata;

  logic            in_fire, out_fire;
  logic [CmpW-1:0] hid_cmp;
  logic            id_static, id_in_range, table_full;
  logic            map_alive;
  logic [CntW-1:0] map_idx, last_idx;
  logic            is_ok;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Checks that need only the counters, made as the beat arrives.
  assign hid_cmp     = CmpW'(handle_id_i);
  assign id_static   = hid_cmp < CmpW'(STATIC_SLOTS);
  assign id_in_range = (hid_cmp < CmpW'(MAX_ENTRIES)) && (hid_cmp < CmpW'(hw_q));
  assign table_full  = dense_q >= CntW'(MAX_ENTRIES);

  // Map entry of the requested id: alive flag over the dense index.
  assign map_alive = map_rdata[CntW];
  assign map_idx   = map_rdata[CntW-1:0];
  assign last_idx  = dense_q - CntW'(1);
  assign is_ok     = (stat_q == hsma_pkg::ST_OK);

  // Read addresses; each RAM is read every cycle and sampled where needed.
  assign map_raddr  = IdW'(handle_id_i);
  assign pay_raddr  = (act_q == hsma_pkg::ACT_DESTROY) ? IdW'(last_idx) : IdW'(map_idx);
  assign rev_raddr  = IdW'(last_idx);
  assign free_raddr = IdW'(ftop_q - CntW'(1));

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    hid_d        = hid_q;
    stat_d       = stat_q;
    newid_d      = newid_q;
    remove_d     = remove_q;
    pay_d        = pay_q;
    dense_d      = dense_q;
    hw_d         = hw_q;
    ftop_d       = ftop_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_rid_d    = out_rid_q;
    out_pay_d    = out_pay_q;
    out_live_d   = out_live_q;
    map_we       = 1'b0;
    map_waddr    = '0;
    map_wdata    = '0;
    pay_we       = 1'b0;
    pay_waddr    = '0;
    pay_wdata    = '0;
    rev_we       = 1'b0;
    rev_waddr    = '0;
    rev_wdata    = '0;
    free_we      = 1'b0;
    free_waddr   = '0;
    free_wdata   = '0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          act_d   = action_i;
          hid_d   = handle_id_i;
          pay_d   = PAYLOAD_W'(payload_in_i);
          stat_d  = hsma_pkg::ST_OK;
          newid_d = '0;
          case (action_i)
            hsma_pkg::ACT_CREATE: begin
              if (table_full) begin
                stat_d  = hsma_pkg::ST_FULL;
                state_d = SDone;
              end else begin
                state_d = SGetId;
              end
            end
            hsma_pkg::ACT_COPY: begin
              if (table_full) begin
                stat_d  = hsma_pkg::ST_FULL;
                state_d = SDone;
              end else if (id_static) begin
                stat_d  = hsma_pkg::ST_STATIC;
                state_d = SDone;
              end else if (!id_in_range) begin
                stat_d  = hsma_pkg::ST_DEAD;
                state_d = SDone;
              end else begin
                state_d = SLook;
              end
            end
            default: begin
              if (id_static) begin
                stat_d  = hsma_pkg::ST_STATIC;
                state_d = SDone;
              end else if (!id_in_range) begin
                stat_d  = hsma_pkg::ST_DEAD;
                state_d = SDone;
              end else begin
                state_d = SLook;
              end
            end
          endcase
        end
      end

      // The map entry is back: check it and start the payload or swap reads.
      SLook: begin
        if (!map_alive || (map_idx >= dense_q)) begin
          stat_d  = hsma_pkg::ST_DEAD;
          state_d = SDone;
        end else begin
          remove_d = IdW'(map_idx);
          if (act_q == hsma_pkg::ACT_DESTROY) begin
            state_d = (map_idx != last_idx) ? SMove : SFree;
          end else begin
            state_d = SFetch;
          end
        end
      end

      SFetch: begin
        pay_d   = pay_rdata;
        state_d = (act_q == hsma_pkg::ACT_COPY) ? SGetId : SDone;
      end

      // Take the most recently freed id, or else a fresh one.
      SGetId: begin
        if (ftop_q != '0) begin
          ftop_d  = ftop_q - CntW'(1);
          state_d = SPop;
        end else begin
          newid_d = IdW'(hw_q);
          hw_d    = hw_q + CntW'(1);
          state_d = SAlloc;
        end
      end

      SPop: begin
        newid_d = free_rdata;
        state_d = SAlloc;
      end

      // Append the entry to the dense array and map the new id to it.
      SAlloc: begin
        map_we    = 1'b1;
        map_waddr = newid_q;
        map_wdata = {1'b1, dense_q};
        pay_we    = 1'b1;
        pay_waddr = IdW'(dense_q);
        pay_wdata = pay_q;
        rev_we    = 1'b1;
        rev_waddr = IdW'(dense_q);
        rev_wdata = newid_q;
        dense_d   = dense_q + CntW'(1);
        state_d   = SDone;
      end

      // Move the last dense entry into the hole and remap its owner.
      SMove: begin
        pay_we    = 1'b1;
        pay_waddr = remove_q;
        pay_wdata = pay_rdata;
        rev_we    = 1'b1;
        rev_waddr = remove_q;
        rev_wdata = rev_rdata;
        map_we    = 1'b1;
        map_waddr = rev_rdata;
        map_wdata = {1'b1, CntW'(remove_q)};
        state_d   = SFree;
      end

      // Kill the id and push it on the free stack.
      SFree: begin
        map_we     = 1'b1;
        map_waddr  = IdW'(hid_q);
        map_wdata  = '0;
        free_we    = 1'b1;
        free_waddr = IdW'(ftop_q);
        free_wdata = IdW'(hid_q);
        ftop_d     = ftop_q + CntW'(1);
        dense_d    = dense_q - CntW'(1);
        state_d    = SDone;
      end

      // Hand the result to the output register once it is free.
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_rid_d    = (is_ok && ((act_q == hsma_pkg::ACT_CREATE) ||
                                    (act_q == hsma_pkg::ACT_COPY))) ?
                         hsma_pkg::HANDLE_W'(newid_q) : '0;
          out_pay_d    = (is_ok && ((act_q == hsma_pkg::ACT_READ) ||
                                    (act_q == hsma_pkg::ACT_COPY))) ?
                         hsma_pkg::WORD_W'(pay_q) : '0;
          out_live_d   = hsma_pkg::LIVE_W'(dense_q);
          state_d      = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      dense_q     <= CntW'(STATIC_SLOTS);
      hw_q        <= CntW'(STATIC_SLOTS);
      ftop_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dense_q     <= dense_d;
      hw_q        <= hw_d;
      ftop_q      <= ftop_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    hid_q        <= hid_d;
    stat_q       <= stat_d;
    newid_q      <= newid_d;
    remove_q     <= remove_d;
    pay_q        <= pay_d;
    out_status_q <= out_status_d;
    out_rid_q    <= out_rid_d;
    out_pay_q    <= out_pay_d;
    out_live_q   <= out_live_d;
  end

  // Id to dense map: alive flag and dense index.
  hsma_ram #(.Width(MapW), .Depth(MAX_ENTRIES)) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  // Dense payload array.
  hsma_ram #(.Width(PAYLOAD_W), .Depth(MAX_ENTRIES)) u_pay_ram (
    .clk_i  (clk_i),
    .we_i   (pay_we),
    .waddr_i(pay_waddr),
    .wdata_i(pay_wdata),
    .raddr_i(pay_raddr),
    .rdata_o(pay_rdata)
  );

  // Owner id of each dense entry.
  hsma_ram #(.Width(IdW), .Depth(MAX_ENTRIES)) u_rev_ram (
    .clk_i  (clk_i),
    .we_i   (rev_we),
    .waddr_i(rev_waddr),
    .wdata_i(rev_wdata),
    .raddr_i(rev_raddr),
    .rdata_o(rev_rdata)
  );

  // Free id stack.
  hsma_ram #(.Width(IdW), .Depth(MAX_ENTRIES)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (free_we),
    .waddr_i(free_waddr),
    .wdata_i(free_wdata),
    .raddr_i(free_raddr),
    .rdata_o(free_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_id_o   = out_rid_q;
  assign payload_out_o = out_pay_q;
  assign live_count_o  = out_live_q;

endmodule

### rtl/hsma_ram.sv
module hsma_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hsma_checker.sv
module hsma_checker #(
  parameter int MAX_ENTRIES  = hsma_pkg::MAX_ENTRIES_DEF,
  parameter int STATIC_SLOTS = hsma_pkg::STATIC_SLOTS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hsma_pkg::STATUS_W-1:0] status_o,
  input logic [hsma_pkg::HANDLE_W-1:0] result_id_o,
  input logic [hsma_pkg::WORD_W-1:0]   payload_out_o,
  input logic [hsma_pkg::LIVE_W-1:0]   live_count_o
);

  logic [hsma_pkg::LIVE_W-1:0] last_live_q;

  // Live count reported with the most recent result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_live_q <= hsma_pkg::LIVE_W'(STATIC_SLOTS);
    end else if (out_valid_o && out_ready_i) begin
      last_live_q <= live_count_o;
    end
  end

  // The sequencer is busy in the cycle after it takes a beat.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request was still in work");

  // A refused request leaves the table as it was.
  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (status_o != hsma_pkg::ST_OK)
      |-> live_count_o == last_live_q)
    else $error("refused request changed the live count");

  // Full is only reported when every slot is taken.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == hsma_pkg::ST_FULL)
      |-> live_count_o == hsma_pkg::LIVE_W'(MAX_ENTRIES))
    else $error("full status with free slots left");

  // A refused request returns neither an id nor a payload.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != hsma_pkg::ST_OK)
      |-> (result_id_o == '0) && (payload_out_o == '0))
    else $error("refused request returned data");

  // A stalled result beat holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
      |=> out_valid_o && $stable(status_o) && $stable(result_id_o) &&
          $stable(payload_out_o) && $stable(live_count_o))
    else $error("stalled result beat changed");

endmodule

bind handle_slot_map_allocator hsma_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .STATIC_SLOTS(STATIC_SLOTS)
) u_hsma_checker (.*);
